FILE: design/rfft_pkg.sv
// Package for the radix-2 FFT block: payload types, controller-to-datapath
// command word, state encoding, saturation helpers and the twiddle table.
// No dependencies.
package rfft_pkg;

   localparam int MAX_LOG2  = 6;
   localparam int DEPTH     = 1 << MAX_LOG2;
   localparam int ADDR_W    = MAX_LOG2;
   localparam int SAMPLE_W  = 16;
   localparam int INT_W     = 24;
   localparam int TW_DEPTH  = DEPTH / 2;
   localparam int TW_W      = MAX_LOG2 - 1;
   localparam int LOG2_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 3;
   localparam int PROD_W    = INT_W + 16;
   localparam int SCALE_W   = INT_W + 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE   = 2'd1;

   // sqrt(1/2) in Q.15 for odd lengths
   localparam logic signed [15:0] INV_SQRT2 = 16'sd23170;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_real;
      logic signed [SAMPLE_W-1:0] in_imag;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_real;
      logic signed [SAMPLE_W-1:0] out_imag;
      logic                       out_last;
   } rsp_type;

   typedef struct packed {
      logic signed [INT_W-1:0] re;
      logic signed [INT_W-1:0] im;
   } cpx_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_MUL,
      ST_WRA,
      ST_WRB,
      ST_EMIT
   } state_type;

   // command word from controller to datapath
   typedef struct packed {
      logic              load_we;
      logic [ADDR_W-1:0] load_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic [TW_W-1:0]   tw_index;
      logic              inverse;
      logic              mul_en;
      logic              wr_a;
      logic              wr_b;
      logic              emit_valid;
      logic              emit_last;
      logic [LOG2_W-1:0] log2_size;
   } cmd_type;

   typedef logic [TW_DEPTH-1:0][31:0] tw_table_type;

   function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W+2:0] x);
      logic signed [INT_W+2:0] hi;
      logic signed [INT_W+2:0] lo;
      hi = (INT_W+3)'((64'sd1 <<< (INT_W-1)) - 64'sd1);
      lo = -hi - (INT_W+3)'(1);
      if (x > hi) return hi[INT_W-1:0];
      else if (x < lo) return lo[INT_W-1:0];
      else return x[INT_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [SCALE_W-1:0] x);
      logic signed [SCALE_W-1:0] hi;
      logic signed [SCALE_W-1:0] lo;
      hi = SCALE_W'((64'sd1 <<< (SAMPLE_W-1)) - 64'sd1);
      lo = -hi - SCALE_W'(1);
      if (x > hi) return hi[SAMPLE_W-1:0];
      else if (x < lo) return lo[SAMPLE_W-1:0];
      else return x[SAMPLE_W-1:0];
   endfunction

   // integer square root, bit by bit
   function automatic logic [63:0] isqrt(input logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = xin;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int q = 0; q < 32; q++) begin
         if (b > x) b = b >> 2;
      end
      for (int q = 0; q < 32; q++) begin
         if (b != 64'd0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // restoring long division, one quotient bit per step
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = 65'd0;
      quo = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint rnd30(input longint x);
      return (x + (longint'(1) <<< 29)) >>> 30;
   endfunction

   function automatic logic [15:0] q15_sat(input longint x);
      longint y;
      y = (x + (longint'(1) <<< 14)) >>> 15;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      return y[15:0];
   endfunction

   // twiddles of the largest length, {cos, sin} in Q1.15; index k for
   // length 2^L maps to k << (MAX_LOG2 - L), which gives the same value
   function automatic tw_table_type build_twiddles();
      longint      rc [MAX_LOG2+2];
      longint      rs [MAX_LOG2+2];
      longint      c;
      longint      s;
      longint      nc;
      longint      ns;
      logic [63:0] cu;
      logic [63:0] su;
      tw_table_type t;
      rc[0] = longint'(1) <<< 30; rs[0] = 0;
      rc[1] = -(longint'(1) <<< 30); rs[1] = 0;
      rc[2] = 0; rs[2] = longint'(1) <<< 30;
      for (int j = 2; j <= MAX_LOG2; j++) begin
         cu = isqrt(64'((rc[j] + (longint'(1) <<< 30))) << 29);
         su = udiv((64'(rs[j]) << 30) + cu, cu << 1);
         rc[j+1] = longint'(cu);
         rs[j+1] = longint'(su);
      end
      for (int k = 0; k < TW_DEPTH; k++) begin
         c = longint'(1) <<< 30;
         s = 0;
         for (int b = 0; b < MAX_LOG2; b++) begin
            if (((k >> b) & 1) != 0) begin
               nc = rnd30(c * rc[MAX_LOG2-b] - s * rs[MAX_LOG2-b]);
               ns = rnd30(c * rs[MAX_LOG2-b] + s * rc[MAX_LOG2-b]);
               c = nc;
               s = ns;
            end
         end
         t[k] = {q15_sat(c), q15_sat(s)};
      end
      return t;
   endfunction

   localparam tw_table_type TWIDDLES = build_twiddles();

endpackage

FILE: design/radix2_fft_top.sv
// Radix-2 decimation-in-time FFT, top level.
// Instantiates rfft_ctrl and rfft_dp; uses rfft_pkg.
//
// Usage:
//  - Write log2_size (index 0, 1..6) and inverse_transform (index 1) through
//    csr_we/csr_index/csr_wdata while the block is idle. A write to a known
//    register drops a partly loaded frame. Unknown indexes are ignored.
//  - Present one sample word on req_data with start; it is taken at an edge
//    where busy and csr_we are low. Samples land at bit-reversed addresses.
//  - After the N-th sample, busy rises for the transform: L stages of N/2
//    butterflies, each through read, multiply and two write states (the memory
//    has one write port, so a' and b' are written apart), then the N emit reads.
//  - Results appear on rsp_data one per cycle, marked by rsp_valid, after
//    each emit read has passed the read, scaling and output registers;
//    out_last marks bin N-1. The receiver cannot stall and must take each
//    word when it is shown.
//  - busy drops after the last emit read; the final words still drain.
//  - Synchronous reset returns to the load state with log2_size = 6,
//    forward transform and an empty frame.
module radix2_fft_top
   import rfft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cmd_type cmd;

   rfft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   rfft_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/rfft_ctrl.sv
// Controller of the radix-2 FFT: configuration registers, load counter,
// butterfly sequencer and emit counter. Uses rfft_pkg.
module rfft_ctrl
   import rfft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output cmd_type              cmd
);

   state_type         state_ff, state_in;
   logic [LOG2_W-1:0] log2_size_ff, log2_size_in;
   logic              inverse_ff, inverse_in;
   logic [ADDR_W-1:0] load_cnt_ff, load_cnt_in;
   logic [TW_W-1:0]   bf_ff, bf_in;
   logic [LOG2_W-1:0] stage_ff, stage_in;
   logic [ADDR_W-1:0] emit_ff, emit_in;

   logic [LOG2_W-1:0] len_log2;
   logic [ADDR_W-1:0] len_mask;
   logic [ADDR_W-1:0] rev_cnt;
   logic [TW_W-1:0]   low_mask;
   logic [TW_W-1:0]   bf_low;
   logic [ADDR_W-1:0] addr_a;
   logic              accept;

   // clamp the length to the supported range
   always_comb begin
      if (log2_size_ff == '0) len_log2 = LOG2_W'(1);
      else if (log2_size_ff > LOG2_W'(MAX_LOG2)) len_log2 = LOG2_W'(MAX_LOG2);
      else len_log2 = log2_size_ff;
      len_mask = ADDR_W'((32'd1 << len_log2) - 32'd1);
   end

   // bit-reversed load address within the active length
   always_comb begin
      for (int i = 0; i < ADDR_W; i++) rev_cnt[i] = load_cnt_ff[ADDR_W-1-i];
      rev_cnt = rev_cnt >> (LOG2_W'(MAX_LOG2) - len_log2);
   end

   // butterfly addresses for the current stage and index
   always_comb begin
      low_mask = TW_W'((32'd1 << stage_ff) - 32'd1);
      bf_low   = bf_ff & low_mask;
      addr_a   = ADDR_W'((ADDR_W'(bf_ff >> stage_ff) << (stage_ff + LOG2_W'(1))))
                 | ADDR_W'(bf_low);
   end

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      log2_size_in  = log2_size_ff;
      inverse_in    = inverse_ff;
      load_cnt_in   = load_cnt_ff;
      bf_in         = bf_ff;
      stage_in      = stage_ff;
      emit_in       = emit_ff;
      cmd           = '0;
      cmd.load_addr = rev_cnt;
      cmd.addr_a    = addr_a;
      cmd.addr_b    = addr_a | ADDR_W'(ADDR_W'(1) << stage_ff);
      cmd.tw_index  = TW_W'(bf_low << (LOG2_W'(TW_W) - stage_ff));
      cmd.inverse   = inverse_ff;
      cmd.log2_size = len_log2;
      case (state_ff)
         ST_LOAD: begin
            if (csr_we) begin
               // a write to a known register drops the partial frame
               if (csr_index == CSR_LOG2_SIZE) begin
                  log2_size_in = csr_wdata;
                  load_cnt_in  = '0;
               end
               if (csr_index == CSR_INVERSE) begin
                  inverse_in  = csr_wdata[0];
                  load_cnt_in = '0;
               end
            end else if (accept) begin
               cmd.load_we = 1'b1;
               if (load_cnt_ff == len_mask) begin
                  load_cnt_in = '0;
                  bf_in       = '0;
                  stage_in    = '0;
                  state_in    = ST_READ;
               end else begin
                  load_cnt_in = load_cnt_ff + ADDR_W'(1);
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_WRA;
         end
         ST_WRA: begin
            cmd.wr_a = 1'b1;
            state_in = ST_WRB;
         end
         ST_WRB: begin
            cmd.wr_b = 1'b1;
            state_in = ST_READ;
            if (bf_ff == TW_W'(len_mask >> 1)) begin
               bf_in = '0;
               if (stage_ff == len_log2 - LOG2_W'(1)) begin
                  emit_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  stage_in = stage_ff + LOG2_W'(1);
               end
            end else begin
               bf_in = bf_ff + TW_W'(1);
            end
         end
         ST_EMIT: begin
            cmd.rd_en      = 1'b1;
            cmd.addr_a     = emit_ff;
            cmd.emit_valid = 1'b1;
            emit_in        = emit_ff + ADDR_W'(1);
            if (emit_ff == len_mask) begin
               cmd.emit_last = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         log2_size_ff <= LOG2_W'(MAX_LOG2);
         inverse_ff   <= 1'b0;
         load_cnt_ff  <= '0;
         bf_ff        <= '0;
         stage_ff     <= '0;
         emit_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         log2_size_ff <= log2_size_in;
         inverse_ff   <= inverse_in;
         load_cnt_ff  <= load_cnt_in;
         bf_ff        <= bf_in;
         stage_ff     <= stage_in;
         emit_ff      <= emit_in;
      end
   end

   // a butterfly always pairs two distinct entries
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> cmd.addr_a != cmd.addr_b)
      else $error("butterfly pairs an entry with itself");

   // the last bin closes the emit pass
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_valid && cmd.emit_last |=> !cmd.emit_valid && !busy)
      else $error("emit pass runs past the last bin");

   // each write of a' is followed by the write of b'
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_a |=> cmd.wr_b)
      else $error("butterfly lost its second write");

endmodule

FILE: design/rfft_dp.sv
// Datapath of the radix-2 FFT: sample memory, twiddle lookup, butterfly
// arithmetic and output scaling. Uses rfft_pkg; driven by rfft_ctrl.
module rfft_dp
   import rfft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cpx_type mem [DEPTH];

   cpx_type                   rd_a_ff, rd_b_ff;
   logic signed [15:0]        wr_ff, wi_ff;
   logic signed [PROD_W-1:0]  prr_ff, pii_ff, pri_ff, pir_ff;
   cpx_type                   diff_ff;
   logic                      ev1_ff, ev2_ff, rsp_valid_ff;
   logic                      last1_ff, last2_ff;
   logic signed [SCALE_W-1:0] sre_ff, sim_ff;
   rsp_type                   rsp_ff;

   logic [31:0]               tw_word;
   logic signed [PROD_W:0]    tr_full, ti_full;
   logic signed [INT_W+1:0]   tr, ti;
   cpx_type                   sum, diff;
   logic                      we;
   logic [ADDR_W-1:0]         waddr;
   cpx_type                   wdata;
   logic signed [SCALE_W-1:0] xre, xim;
   logic [LOG2_W+1:0]         sh;
   logic signed [SCALE_W-1:0] rnd;

   assign tw_word = TWIDDLES[cmd.tw_index];

   // complete the butterfly: round the product, add and subtract
   always_comb begin
      tr_full = (PROD_W+1)'(prr_ff) - (PROD_W+1)'(pii_ff) + (PROD_W+1)'(1 << 14);
      ti_full = (PROD_W+1)'(pri_ff) + (PROD_W+1)'(pir_ff) + (PROD_W+1)'(1 << 14);
      tr      = (INT_W+2)'(tr_full >>> 15);
      ti      = (INT_W+2)'(ti_full >>> 15);
      sum.re  = sat_int((INT_W+3)'(rd_a_ff.re) + (INT_W+3)'(tr));
      sum.im  = sat_int((INT_W+3)'(rd_a_ff.im) + (INT_W+3)'(ti));
      diff.re = sat_int((INT_W+3)'(rd_a_ff.re) - (INT_W+3)'(tr));
      diff.im = sat_int((INT_W+3)'(rd_a_ff.im) - (INT_W+3)'(ti));
   end

   // single write port: load, then a', then b'
   always_comb begin
      we    = cmd.load_we || cmd.wr_a || cmd.wr_b;
      waddr = cmd.addr_b;
      wdata = diff_ff;
      if (cmd.load_we) begin
         waddr    = cmd.load_addr;
         wdata.re = INT_W'(req_data.in_real);
         wdata.im = INT_W'(req_data.in_imag);
      end else if (cmd.wr_a) begin
         waddr = cmd.addr_a;
         wdata = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.rd_en) begin
         rd_a_ff <= mem[cmd.addr_a];
         rd_b_ff <= mem[cmd.addr_b];
      end
   end

   // latch twiddle, negate sine for the forward transform
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         wr_ff <= tw_word[31:16];
         wi_ff <= cmd.inverse ? signed'(tw_word[15:0]) : -signed'(tw_word[15:0]);
      end
   end

   // register the four partial products
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prr_ff <= PROD_W'(rd_b_ff.re) * PROD_W'(wr_ff);
         pii_ff <= PROD_W'(rd_b_ff.im) * PROD_W'(wi_ff);
         pri_ff <= PROD_W'(rd_b_ff.re) * PROD_W'(wi_ff);
         pir_ff <= PROD_W'(rd_b_ff.im) * PROD_W'(wr_ff);
      end
      if (cmd.wr_a) diff_ff <= diff;
   end

   // output scaling: even length shifts, odd length multiplies by sqrt(1/2)
   always_comb begin
      sh  = (LOG2_W+2)'(15) + (LOG2_W+2)'(cmd.log2_size >> 1);
      rnd = SCALE_W'(1) <<< (sh - (LOG2_W+2)'(1));
      if (cmd.log2_size[0]) begin
         xre = SCALE_W'(rd_a_ff.re) * SCALE_W'(INV_SQRT2);
         xim = SCALE_W'(rd_a_ff.im) * SCALE_W'(INV_SQRT2);
      end else begin
         xre = SCALE_W'(rd_a_ff.re) <<< 15;
         xim = SCALE_W'(rd_a_ff.im) <<< 15;
      end
   end

   always_ff @(posedge clock) begin
      sre_ff <= xre;
      sim_ff <= xim;
      last1_ff <= cmd.emit_last;
      last2_ff <= last1_ff;
      if (ev2_ff) begin
         rsp_ff.out_real <= sat_out((sre_ff + rnd) >>> sh);
         rsp_ff.out_imag <= sat_out((sim_ff + rnd) >>> sh);
         rsp_ff.out_last <= last2_ff;
      end
   end

   // advance the emit strobes
   always_ff @(posedge clock) begin
      if (reset) begin
         ev1_ff       <= 1'b0;
         ev2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev1_ff       <= cmd.emit_valid;
         ev2_ff       <= ev1_ff;
         rsp_valid_ff <= ev2_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: dv/tb_radix2_fft_top.sv
// Testbench for radix2_fft_top: random and directed sample frames at several
// lengths and directions, checked bin by bin against a predictor of the transform.
// Depends on rfft_pkg and the radix2_fft_top RTL.
`timescale 1ns / 100ps

import rfft_pkg::*;

class fft_scoreboard;
   rsp_type   expected_bins[$];
   int        errors;
   bit [2:0]  size_reg;
   bit        inverse_reg;
   int        fill;
   longint    store_re[DEPTH];
   longint    store_im[DEPTH];
   longint    rot_c[MAX_LOG2+2];
   longint    rot_s[MAX_LOG2+2];

   function new();
      longint unsigned x;
      longint unsigned r;
      longint unsigned t;
      errors = 0;
      size_reg = 3'd6;
      inverse_reg = 1'b0;
      fill = 0;
      // half-angle rotations in Q2.30
      rot_c[0] = longint'(1) <<< 30; rot_s[0] = 0;
      rot_c[1] = -(longint'(1) <<< 30); rot_s[1] = 0;
      rot_c[2] = 0; rot_s[2] = longint'(1) <<< 30;
      for (int j = 2; j <= MAX_LOG2; j++) begin
         x = longint'(rot_c[j] + (longint'(1) <<< 30)) << 29;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
         end
         rot_c[j+1] = longint'(r);
         rot_s[j+1] = longint'(((longint'(rot_s[j]) << 30) + r) / (2 * r));
      end
   endfunction

   function longint round_sh(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function longint clip(longint x, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function int active_log2();
      if (size_reg < 1) return 1;
      if (size_reg > MAX_LOG2) return MAX_LOG2;
      return size_reg;
   endfunction

   function void twiddle(int k, int lg, output longint wr, output longint wi);
      longint c;
      longint s;
      longint nc;
      c = longint'(1) <<< 30;
      s = 0;
      for (int b = 0; b < lg; b++) begin
         if ((k >> b) & 1) begin
            nc = round_sh(c * rot_c[lg-b] - s * rot_s[lg-b], 30);
            s  = round_sh(c * rot_s[lg-b] + s * rot_c[lg-b], 30);
            c  = nc;
         end
      end
      wr = clip(round_sh(c, 15), 16);
      wi = clip(round_sh(s, 15), 16);
      if (!inverse_reg) wi = -wi;
   endfunction

   // run the butterflies in place and queue the scaled bins
   function void transform(int lg);
      int      n;
      int      half;
      int      groups;
      int      ia;
      int      ib;
      longint  wr;
      longint  wi;
      longint  tr;
      longint  ti;
      longint  yr;
      longint  yi;
      rsp_type bin;
      n = 1 << lg;
      for (int st = 0; st < lg; st++) begin
         half = 1 << st;
         groups = 1 << (lg - 1 - st);
         for (int g = 0; g < groups; g++) begin
            for (int i = 0; i < half; i++) begin
               twiddle(groups * i, lg, wr, wi);
               ia = g * half * 2 + i;
               ib = ia + half;
               tr = round_sh(store_re[ib] * wr - store_im[ib] * wi, 15);
               ti = round_sh(store_re[ib] * wi + store_im[ib] * wr, 15);
               store_re[ib] = clip(store_re[ia] - tr, INT_W);
               store_im[ib] = clip(store_im[ia] - ti, INT_W);
               store_re[ia] = clip(store_re[ia] + tr, INT_W);
               store_im[ia] = clip(store_im[ia] + ti, INT_W);
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         if (lg % 2 == 0) begin
            yr = round_sh(store_re[i], lg / 2);
            yi = round_sh(store_im[i], lg / 2);
         end else begin
            yr = round_sh(store_re[i] * 23170, 15 + (lg - 1) / 2);
            yi = round_sh(store_im[i] * 23170, 15 + (lg - 1) / 2);
         end
         bin.out_real = 16'(clip(yr, SAMPLE_W));
         bin.out_imag = 16'(clip(yi, SAMPLE_W));
         bin.out_last = (i == n - 1);
         expected_bins.insert(expected_bins.size(), bin);
      end
   endfunction

   // note an accepted sample word; a full frame queues its bins
   function void note_sample(req_type d);
      int lg;
      int addr;
      lg = active_log2();
      addr = 0;
      for (int i = 0; i < lg; i++) addr = (addr << 1) | ((fill >> i) & 1);
      store_re[addr] = longint'(d.in_real);
      store_im[addr] = longint'(d.in_imag);
      fill++;
      if (fill == (1 << lg)) begin
         fill = 0;
         transform(lg);
      end
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      if (idx == CSR_LOG2_SIZE) begin
         size_reg = val;
         fill = 0;
      end else if (idx == CSR_INVERSE) begin
         inverse_reg = val[0];
         fill = 0;
      end
   endfunction

   task report(string what, int got, int want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   task check_bin(rsp_type got);
      rsp_type want;
      if (expected_bins.size() == 0) begin
         report("unexpected word", got.out_real, 0);
         return;
      end
      want = expected_bins.pop_front();
      if (got.out_real !== want.out_real) report("out_real", got.out_real, want.out_real);
      if (got.out_imag !== want.out_imag) report("out_imag", got.out_imag, want.out_imag);
      if (got.out_last !== want.out_last) report("out_last", got.out_last, want.out_last);
   endtask
endclass

module tb_radix2_fft_top;
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   fft_scoreboard sb = new();
   bit            gaps_on;
   int            burst_left;
   int            samples_sent;

   radix2_fft_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // watch both channels on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_sample(req_data);
         if (rsp_valid) sb.check_bin(rsp_data);
      end
   end

   function req_type pick_sample();
      req_type d;
      logic [15:0] v[2];
      for (int i = 0; i < 2; i++) begin
         case ($urandom_range(0, 7))
            0: v[i] = 16'h8000;
            1: v[i] = 16'h7fff;
            2: v[i] = 16'h0000;
            default: v[i] = 16'($urandom);
         endcase
      end
      d.in_real = v[0];
      d.in_imag = v[1];
      return d;
   endfunction

   // hold start until the word is taken, then maybe drop for a gap
   task send_sample(input req_type d);
      start <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (busy);
      samples_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(0, 10);
         end else begin
            burst_left--;
         end
      end
   endtask

   // drain all pending bins, let the pipe settle, then write
   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_bins.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task send_frames(input int words);
      for (int i = 0; i < words; i++) send_sample(pick_sample());
   endtask

   initial begin
      req_type d;
      int lg;
      int n;
      samples_sent = 0;
      burst_left = 0;
      gaps_on = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: length two at full scale, both signs, both directions
      write_reg(CSR_LOG2_SIZE, 3'd1);
      d.in_real = 16'sh7fff; d.in_imag = 16'sh7fff; send_sample(d);
      d.in_real = 16'sh7fff; d.in_imag = 16'sh8000; send_sample(d);
      d.in_real = 16'sh8000; d.in_imag = 16'sh8000; send_sample(d);
      d.in_real = 16'sh8000; d.in_imag = 16'sh7fff; send_sample(d);
      write_reg(CSR_INVERSE, 3'd1);
      d.in_real = 16'sh7fff; d.in_imag = 16'sh0000; send_sample(d);
      d.in_real = 16'sh0001; d.in_imag = 16'shffff; send_sample(d);
      // length zero acts as two
      write_reg(CSR_LOG2_SIZE, 3'd0);
      send_frames(2);
      // length four impulse, forward; then abandon a partial frame
      write_reg(CSR_INVERSE, 3'd0);
      write_reg(CSR_LOG2_SIZE, 3'd2);
      d.in_real = 16'sh7fff; d.in_imag = 16'sh8000; send_sample(d);
      d = '0;
      repeat (3) send_sample(d);
      send_frames(3);
      write_reg(CSR_LOG2_SIZE, 3'd3);
      // unknown indexes are ignored and keep the partial frame
      send_frames(3);
      write_reg(2'd2, 3'd7);
      write_reg(2'd3, 3'd5);
      send_frames(5);

      // random phases, mostly short lengths
      while (samples_sent < 165) begin
         case ($urandom_range(0, 11))
            0: lg = 0;
            1: lg = 7;
            2: lg = 6;
            3, 4: lg = 3;
            5, 6: lg = 4;
            7: lg = 5;
            8, 9: lg = 1;
            default: lg = 2;
         endcase
         gaps_on = $urandom_range(0, 2) != 0;
         write_reg(CSR_LOG2_SIZE, 3'(lg));
         write_reg(CSR_INVERSE, 3'($urandom_range(0, 7)));
         if ($urandom_range(0, 4) == 0) write_reg(2'($urandom_range(2, 3)), 3'($urandom));
         n = 1 << (lg < 1 ? 1 : (lg > MAX_LOG2 ? MAX_LOG2 : lg));
         send_frames(n >= 32 ? n : n * $urandom_range(1, 3));
         // sometimes leave a partial frame to be dropped by the next write
         if ($urandom_range(0, 4) == 0) send_frames($urandom_range(1, n - 1));
      end

      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_bins.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_radix2_fft_top: done, clean");
      end else begin
         $display("tb_radix2_fft_top: done, errors");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #5000000;
      $display("tb_radix2_fft_top: done, errors");
      $finish;
   end
endmodule

FILE: filelist.f
design/rfft_pkg.sv
design/rfft_ctrl.sv
design/rfft_dp.sv
design/radix2_fft_top.sv
dv/tb_radix2_fft_top.sv
